// File: rtl/core/pts_pkg.sv
// ---------------------------------------------------------------------------
// pts_pkg
// shared types, codes, constants and helper functions of the pan/tilt stepper
// ---------------------------------------------------------------------------
package pts_pkg;

    localparam int unsigned PosW   = 10;
    localparam int unsigned DimW   = 12;
    localparam int unsigned OffW   = 14;
    localparam int unsigned StepW  = 4;
    localparam int unsigned SumW   = 12;
    localparam int unsigned ByteW  = 8;
    localparam int unsigned CntW   = 3;
    localparam int unsigned CfgAW  = 2;

    localparam int unsigned InDataW  = 56;
    localparam int unsigned OutDataW = 32;

    localparam logic [PosW-1:0] PosMax = 10'd999;

    localparam logic signed [OffW-1:0] FarLimit  = 14'sd200;
    localparam logic signed [OffW-1:0] NearLimit = 14'sd100;
    localparam logic signed [StepW-1:0] FarStep  = 4'sd4;

    localparam logic [DimW-1:0] FrameWRst = 12'd1600;
    localparam logic [DimW-1:0] FrameHRst = 12'd900;
    localparam logic [PosW-1:0] HomePanRst  = 10'd750;
    localparam logic [PosW-1:0] HomeTiltRst = 10'd735;
    localparam logic [PosW-1:0] PanRst  = 10'd750;
    localparam logic [PosW-1:0] TiltRst = 10'd725;

    localparam logic [ByteW-1:0] ChP    = 8'h70;
    localparam logic [ByteW-1:0] ChT    = 8'h74;
    localparam logic [ByteW-1:0] ChZero = 8'h30;

    localparam logic [CntW-1:0] LastIdx = 3'd7;

    typedef enum logic [2:0] {
        OP_TRACK   = 3'd0,
        OP_HOME    = 3'd1,
        OP_PAN_UP  = 3'd2,
        OP_PAN_DN  = 3'd3,
        OP_TILT_UP = 3'd4,
        OP_TILT_DN = 3'd5
    } t_op;

    typedef enum logic [CfgAW-1:0] {
        CFG_FRAME_W   = 2'd0,
        CFG_FRAME_H   = 2'd1,
        CFG_HOME_PAN  = 2'd2,
        CFG_HOME_TILT = 2'd3
    } t_cfg;

    typedef enum logic [CntW-1:0] {
        B_P     = 3'd0,
        B_PAN2  = 3'd1,
        B_PAN1  = 3'd2,
        B_PAN0  = 3'd3,
        B_T     = 3'd4,
        B_TILT2 = 3'd5,
        B_TILT1 = 3'd6,
        B_TILT0 = 3'd7
    } t_slot;

    typedef struct packed {
        logic            load;
        logic [PosW-1:0] pan;
        logic [PosW-1:0] tilt;
    } t_run;

    function automatic logic signed [StepW-1:0] deadband(input logic signed [OffW-1:0] off);
        logic signed [StepW-1:0] s;
        if (off > FarLimit) begin
            s = FarStep;
        end else if (off > NearLimit) begin
            s = 4'sd1;
        end else if (off < -FarLimit) begin
            s = -FarStep;
        end else if (off < -NearLimit) begin
            s = -4'sd1;
        end else begin
            s = 4'sd0;
        end
        return s;
    endfunction

    function automatic logic [PosW-1:0] clamp_pos(input logic signed [SumW-1:0] v);
        logic [PosW-1:0] r;
        if (v < 12'sd0) begin
            r = '0;
        end else if (v > $signed({2'b00, PosMax})) begin
            r = PosMax;
        end else begin
            r = v[PosW-1:0];
        end
        return r;
    endfunction

    // three decimal digits {hundreds, tens, ones} of a value up to 999
    function automatic logic [11:0] bcd3(input logic [PosW-1:0] v);
        logic [15:0] ph;
        logic [3:0]  h;
        logic [6:0]  rem;
        logic [14:0] pt;
        logic [3:0]  t;
        logic [3:0]  o;
        logic [6:0]  hx100;
        logic [6:0]  tx10;
        ph    = 16'({6'd0, v} * 16'd41);
        h     = ph[15:12];
        hx100 = 7'(v - 10'(h * 10'd100));
        rem   = hx100;
        pt    = 15'({8'd0, rem} * 15'd205);
        t     = pt[14:11];
        tx10  = 7'(rem - 7'(t * 7'd10));
        o     = tx10[3:0];
        return {h, t, o};
    endfunction

endpackage

// File: rtl/core/pts_step.sv
// ---------------------------------------------------------------------------
// pts_step
// command register, settings registers and pan/tilt position update
// ---------------------------------------------------------------------------
module pts_step (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pts_pkg::CfgAW-1:0]    i_cfg_addr,
    input  logic [pts_pkg::DimW-1:0]     i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pts_pkg::InDataW-1:0]  i_data,
    input  logic                         i_free,
    output pts_pkg::t_run                o_run
);
    import pts_pkg::*;

    logic [DimW-1:0] r_frame_w;
    logic [DimW-1:0] r_frame_h;
    logic [PosW-1:0] r_home_pan;
    logic [PosW-1:0] r_home_tilt;

    logic            r_in_valid;
    logic [2:0]      r_op;
    logic [DimW-1:0] r_bx;
    logic [DimW-1:0] r_by;
    logic [DimW-1:0] r_bw;
    logic [DimW-1:0] r_bh;

    logic [PosW-1:0] r_pan;
    logic [PosW-1:0] r_tilt;
    logic [PosW-1:0] n_pan;
    logic [PosW-1:0] n_tilt;

    logic                    take;
    logic [DimW:0]           cx_sum;
    logic [DimW:0]           cy_sum;
    logic signed [OffW-1:0]  off_x;
    logic signed [OffW-1:0]  off_y;
    logic signed [StepW-1:0] step_x;
    logic signed [StepW-1:0] step_y;
    logic signed [SumW-1:0]  pan_s;
    logic signed [SumW-1:0]  tilt_s;

    assign o_ready = !r_in_valid;
    assign take    = r_in_valid && i_free;

    // settings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w   <= FrameWRst;
            r_frame_h   <= FrameHRst;
            r_home_pan  <= HomePanRst;
            r_home_tilt <= HomeTiltRst;
        end else if (i_cfg_we) begin
            case (t_cfg'(i_cfg_addr))
                CFG_FRAME_W:   r_frame_w   <= i_cfg_wdata;
                CFG_FRAME_H:   r_frame_h   <= i_cfg_wdata;
                CFG_HOME_PAN:  r_home_pan  <= i_cfg_wdata[PosW-1:0];
                CFG_HOME_TILT: r_home_tilt <= i_cfg_wdata[PosW-1:0];
                default: ;
            endcase
        end
    end

    // command register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op <= i_data[2:0];
            r_bx <= i_data[14:3];
            r_by <= i_data[26:15];
            r_bw <= i_data[38:27];
            r_bh <= i_data[50:39];
        end
    end

    // box centre offsets, x mirrored
    always_comb begin
        cx_sum = {1'b0, r_bx} + {2'b00, r_bw[DimW-1:1]};
        cy_sum = {1'b0, r_by} + {2'b00, r_bh[DimW-1:1]};
        off_x  = $signed({2'b00, r_frame_w}) - $signed({1'b0, cx_sum})
                 - $signed({3'b000, r_frame_w[DimW-1:1]});
        off_y  = $signed({1'b0, cy_sum}) - $signed({3'b000, r_frame_h[DimW-1:1]});
        step_x = deadband(off_x);
        step_y = deadband(off_y);
    end

    always_comb begin
        pan_s  = $signed({2'b00, r_pan});
        tilt_s = $signed({2'b00, r_tilt});
        case (r_op)
            OP_TRACK: begin
                pan_s  = $signed({2'b00, r_pan})  + SumW'(step_x);
                tilt_s = $signed({2'b00, r_tilt}) + SumW'(step_y);
            end
            OP_HOME: begin
                pan_s  = $signed({2'b00, r_home_pan});
                tilt_s = $signed({2'b00, r_home_tilt});
            end
            OP_PAN_UP:  pan_s  = $signed({2'b00, r_pan}) + 12'sd1;
            OP_PAN_DN:  pan_s  = $signed({2'b00, r_pan}) - 12'sd1;
            OP_TILT_UP: tilt_s = $signed({2'b00, r_tilt}) + 12'sd1;
            OP_TILT_DN: tilt_s = $signed({2'b00, r_tilt}) - 12'sd1;
            default: ;
        endcase
        n_pan  = clamp_pos(pan_s);
        n_tilt = clamp_pos(tilt_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan  <= PanRst;
            r_tilt <= TiltRst;
        end else if (take) begin
            r_pan  <= n_pan;
            r_tilt <= n_tilt;
        end
    end

    assign o_run.load = take;
    assign o_run.pan  = r_pan;
    assign o_run.tilt = r_tilt;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pan <= PosMax) && (r_tilt <= PosMax))
        else $error("position out of range");

    a_hold_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !take |=> $stable(r_pan) && $stable(r_tilt))
        else $error("position moved without a command");

    a_take_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> !r_in_valid)
        else $error("command register not released");

endmodule

// File: rtl/core/pts_ser.sv
// ---------------------------------------------------------------------------
// pts_ser
// eight-beat ascii run: p, three pan digits, t, three tilt digits
// ---------------------------------------------------------------------------
module pts_ser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pts_pkg::t_run                 i_run,
    output logic                          o_free,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [pts_pkg::OutDataW-1:0]  o_data,
    output logic                          o_last
);
    import pts_pkg::*;

    logic            r_busy;
    logic [CntW-1:0] r_cnt;
    logic            beat;
    logic [11:0]     pan_d;
    logic [11:0]     tilt_d;
    logic [ByteW-1:0] ch;

    assign beat    = r_busy && i_ready;
    assign o_free  = !r_busy || (beat && (r_cnt == LastIdx));
    assign o_valid = r_busy;
    assign o_last  = r_cnt == LastIdx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_run.load) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (beat) begin
            if (r_cnt == LastIdx) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 3'd1;
        end
    end

    always_comb begin
        pan_d  = bcd3(i_run.pan);
        tilt_d = bcd3(i_run.tilt);
        case (t_slot'(r_cnt))
            B_P:     ch = ChP;
            B_PAN2:  ch = ChZero + {4'd0, pan_d[11:8]};
            B_PAN1:  ch = ChZero + {4'd0, pan_d[7:4]};
            B_PAN0:  ch = ChZero + {4'd0, pan_d[3:0]};
            B_T:     ch = ChT;
            B_TILT2: ch = ChZero + {4'd0, tilt_d[11:8]};
            B_TILT1: ch = ChZero + {4'd0, tilt_d[7:4]};
            B_TILT0: ch = ChZero + {4'd0, tilt_d[3:0]};
            default: ch = ChP;
        endcase
    end

    assign o_data = {4'd0, i_run.tilt, i_run.pan, ch};

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_run.load |-> o_free)
        else $error("run loaded over a busy run");

    a_end_of_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (beat && (r_cnt == LastIdx) && !i_run.load) |=> !r_busy)
        else $error("run did not end after last beat");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_ready && !i_run.load) |=> $stable(r_cnt) && r_busy)
        else $error("run advanced while stalled");

    a_new_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_run.load |=> r_busy && (r_cnt == '0))
        else $error("run did not start at first beat");

endmodule

// File: rtl/core/pan_tilt_deadband_stepper_top.sv
// ---------------------------------------------------------------------------
// pan_tilt_deadband_stepper_top
// pan/tilt dead-band stepper with ascii command string output
// ---------------------------------------------------------------------------
// slave stream: one command beat per video frame (track, home or nudge);
//   a command is held in a one-entry input register, so the next command is
//   taken while the previous string is still being sent
// master stream: eight beats per command, 'p' ddd 't' ddd, tlast on the
//   eighth; every beat also carries the pan and tilt positions
// settings port: frame size and home positions, written while idle
// start: a command waits in the input register until the string side is free,
//   then the run is loaded and its first byte goes out; the eight byte beats
//   share the single master stream, so a new string starts after the last beat
// reset: positions go to pan 750 / tilt 725, settings to their defaults,
//   both streams empty
// receiver stall: the string holds its current byte; once the input register
//   is full the slave side drops tready until the run ends
// ---------------------------------------------------------------------------
module pan_tilt_deadband_stepper_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pts_pkg::CfgAW-1:0]     i_cfg_addr,
    input  logic [pts_pkg::DimW-1:0]      i_cfg_wdata,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // operation[2:0], box_x[14:3], box_y[26:15], box_width[38:27], box_height[50:39]
    input  logic [pts_pkg::InDataW-1:0]   i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // serial_byte[7:0], pan_now[17:8], tilt_now[27:18]
    output logic [pts_pkg::OutDataW-1:0]  o_m_axis_tdata,
    output logic                          o_m_axis_tlast
);
    import pts_pkg::*;

    t_run run;
    logic free;

    pts_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .i_free      (free),
        .o_run       (run)
    );

    pts_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (run),
        .o_free  (free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// File: tb/sv/tb_pan_tilt_deadband_stepper_top.sv
// ---------------------------------------------------------------------------
// tb_pan_tilt_deadband_stepper_top
// self-checking bench for the pan/tilt dead-band stepper: commands go in on
// the slave stream, a local position model builds the eight-byte string each
// one should produce, and every master beat is compared against it; covers
// reset positions, every command, dead-band edges, saturation, frame size
// extremes and random traffic under sender gaps and receiver stalls
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_pan_tilt_deadband_stepper_top;

    import pts_pkg::*;

    localparam logic [2:0] OpSpare6 = 3'd6;
    localparam logic [2:0] OpSpare7 = 3'd7;
    localparam int CycleLimit = 200000;
    localparam int ItemsPerPhase = 48;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic [9:0] pan;
        logic [9:0] tilt;
    } t_serial_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CfgAW-1:0]     i_cfg_addr = '0;
    logic [DimW-1:0]      i_cfg_wdata = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [InDataW-1:0]   i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [OutDataW-1:0]  o_m_axis_tdata;
    logic                 o_m_axis_tlast;

    // settings and positions as the block should hold them
    logic [11:0] set_frame_w = FrameWRst;
    logic [11:0] set_frame_h = FrameHRst;
    logic [9:0]  set_home_pan = HomePanRst;
    logic [9:0]  set_home_tilt = HomeTiltRst;
    logic [9:0]  dial_pan = PanRst;
    logic [9:0]  dial_tilt = TiltRst;

    t_serial_beat expected_serial_q[$];
    int errors = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    pan_tilt_deadband_stepper_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("FAIL pan_tilt_deadband_stepper_top");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic logic signed [3:0] band_step(input logic signed [15:0] off);
        if (off > 16'sd200) return 4'sd4;
        if (off > 16'sd100) return 4'sd1;
        if (off < -16'sd200) return -4'sd4;
        if (off < -16'sd100) return -4'sd1;
        return 4'sd0;
    endfunction

    function automatic logic [9:0] clamp_to_dial(input logic signed [12:0] v);
        if (v < 13'sd0) return 10'd0;
        if (v > 13'sd999) return 10'd999;
        return v[9:0];
    endfunction

    function automatic logic [23:0] decimal_ascii(input logic [9:0] v);
        logic [9:0] h;
        logic [9:0] t;
        logic [9:0] o;
        h = v / 10'd100;
        t = (v / 10'd10) % 10'd10;
        o = v % 10'd10;
        return {8'(ChZero + h), 8'(ChZero + t), 8'(ChZero + o)};
    endfunction

    function automatic logic [11:0] fit12(input int v);
        if (v < 0) return 12'd0;
        if (v > 4095) return 12'd4095;
        return 12'(v);
    endfunction

    // steps the position model and queues the eight beats of the string
    task automatic predict_command_string(input logic [2:0] op, input logic [11:0] bx,
                                          input logic [11:0] by, input logic [11:0] bw,
                                          input logic [11:0] bh);
        logic signed [15:0] off_x;
        logic signed [15:0] off_y;
        logic signed [12:0] pan_sum;
        logic signed [12:0] tilt_sum;
        logic [63:0]        text;
        t_serial_beat       beat;
        int                 k;
        pan_sum = $signed({3'b000, dial_pan});
        tilt_sum = $signed({3'b000, dial_tilt});
        off_x = $signed({4'h0, set_frame_w}) - $signed({4'h0, bx})
              - $signed({5'h00, bw[11:1]}) - $signed({5'h00, set_frame_w[11:1]});
        off_y = $signed({4'h0, by}) + $signed({5'h00, bh[11:1]})
              - $signed({5'h00, set_frame_h[11:1]});
        case (op)
            OP_TRACK: begin
                pan_sum = pan_sum + band_step(off_x);
                tilt_sum = tilt_sum + band_step(off_y);
            end
            OP_HOME: begin
                pan_sum = $signed({3'b000, set_home_pan});
                tilt_sum = $signed({3'b000, set_home_tilt});
            end
            OP_PAN_UP: pan_sum = pan_sum + 13'sd1;
            OP_PAN_DN: pan_sum = pan_sum - 13'sd1;
            OP_TILT_UP: tilt_sum = tilt_sum + 13'sd1;
            OP_TILT_DN: tilt_sum = tilt_sum - 13'sd1;
            default: ;
        endcase
        dial_pan = clamp_to_dial(pan_sum);
        dial_tilt = clamp_to_dial(tilt_sum);
        text = {ChP, decimal_ascii(dial_pan), ChT, decimal_ascii(dial_tilt)};
        for (k = 0; k < 8; k++) begin
            beat.ch = text[63 - 8 * k -: 8];
            beat.last = (k == 7);
            beat.pan = dial_pan;
            beat.tilt = dial_tilt;
            expected_serial_q.push_back(beat);
        end
    endtask

    task automatic send_command(input logic [2:0] op, input logic [11:0] bx,
                                input logic [11:0] by, input logic [11:0] bw,
                                input logic [11:0] bh);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {5'd0, bh, bw, by, bx, op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_command_string(op, bx, by, bw, bh);
    endtask

    task automatic wait_drain();
        i_s_axis_tvalid <= 1'b0;
        while (expected_serial_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_setting(input t_cfg idx, input logic [11:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        case (idx)
            CFG_FRAME_W: set_frame_w = value;
            CFG_FRAME_H: set_frame_h = value;
            CFG_HOME_PAN: set_home_pan = value[9:0];
            CFG_HOME_TILT: set_home_tilt = value[9:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_positions();
        send_command(OpSpare6, 12'hFFF, 12'h000, 12'hFFF, 12'h000);
    endtask

    task automatic test_each_command();
        send_command(OP_HOME, 12'hABC, 12'h123, 12'h456, 12'h789);
        send_command(OP_PAN_UP, 12'd0, 12'd0, 12'd0, 12'd0);
        send_command(OP_PAN_DN, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_command(OP_TILT_UP, 12'd0, 12'd0, 12'd0, 12'd0);
        send_command(OP_TILT_DN, 12'h555, 12'hAAA, 12'h555, 12'hAAA);
        send_command(OpSpare7, 12'd0, 12'd0, 12'd0, 12'd0);
    endtask

    // both edges of each band, odd box sizes so the halving rounds down
    task automatic test_dead_bands();
        int band_edge [8];
        int k;
        band_edge = '{201, 200, 101, 100, -100, -101, -200, -201};
        for (k = 0; k < 8; k++) begin
            send_command(OP_TRACK, 12'(800 - band_edge[k] - 3), 12'(450 - band_edge[k] - 4),
                         12'd7, 12'd9);
        end
        send_command(OP_TRACK, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_command(OP_TRACK, 12'd0, 12'd0, 12'd0, 12'd0);
    endtask

    task automatic test_saturation();
        wait_drain();
        write_setting(CFG_HOME_PAN, 12'd1023);
        write_setting(CFG_HOME_TILT, 12'd0);
        send_command(OP_HOME, 12'd0, 12'd0, 12'd0, 12'd0);
        send_command(OP_TRACK, 12'd0, 12'd0, 12'd0, 12'd0);
        send_command(OP_PAN_UP, 12'd0, 12'd0, 12'd0, 12'd0);
        send_command(OP_TILT_DN, 12'd0, 12'd0, 12'd0, 12'd0);
        wait_drain();
        write_setting(CFG_HOME_PAN, 12'd0);
        write_setting(CFG_HOME_TILT, 12'd999);
        send_command(OP_HOME, 12'd0, 12'd0, 12'd0, 12'd0);
        send_command(OP_TRACK, 12'd4095, 12'd4095, 12'd0, 12'd0);
        send_command(OP_PAN_DN, 12'd0, 12'd0, 12'd0, 12'd0);
        send_command(OP_TILT_UP, 12'd0, 12'd0, 12'd0, 12'd0);
    endtask

    task automatic test_frame_extremes();
        wait_drain();
        write_setting(CFG_HOME_PAN, 12'd500);
        write_setting(CFG_HOME_TILT, 12'd500);
        write_setting(CFG_FRAME_W, 12'd1);
        write_setting(CFG_FRAME_H, 12'd1);
        send_command(OP_HOME, 12'd0, 12'd0, 12'd0, 12'd0);
        send_command(OP_TRACK, 12'd0, 12'd0, 12'd1, 12'd1);
        send_command(OP_TRACK, 12'd300, 12'd300, 12'd0, 12'd0);
        wait_drain();
        write_setting(CFG_FRAME_W, 12'd4095);
        write_setting(CFG_FRAME_H, 12'd4095);
        send_command(OP_TRACK, 12'd0, 12'd0, 12'd0, 12'd0);
        send_command(OP_TRACK, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
    endtask

    task automatic send_random_command();
        int          pick;
        int          off;
        logic [2:0]  op;
        logic [11:0] bx;
        logic [11:0] by;
        logic [11:0] bw;
        logic [11:0] bh;
        pick = $urandom_range(99);
        bx = 12'($urandom);
        by = 12'($urandom);
        bw = 12'($urandom);
        bh = 12'($urandom);
        if (pick < 60) begin
            // box placed around the dead-band edges of the current frame
            bw = 12'($urandom_range(0, 600));
            bh = 12'($urandom_range(0, 600));
            off = int'($urandom_range(0, 640)) - 320;
            bx = fit12(int'(set_frame_w) - int'(set_frame_w) / 2 - off - int'(bw) / 2);
            off = int'($urandom_range(0, 640)) - 320;
            by = fit12(int'(set_frame_h) / 2 + off - int'(bh) / 2);
            op = OP_TRACK;
        end else if (pick < 75) begin
            op = OP_TRACK;
        end else if (pick < 85) begin
            op = OP_HOME;
        end else if (pick < 97) begin
            op = 3'($urandom_range(OP_PAN_UP, OP_TILT_DN));
        end else begin
            op = 3'($urandom_range(OpSpare6, OpSpare7));
        end
        send_command(op, bx, by, bw, bh);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input bit pause_midway);
        int k;
        wait_drain();
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        if ($urandom_range(1)) begin
            write_setting(CFG_FRAME_W, 12'($urandom_range(320, 1920)));
            write_setting(CFG_FRAME_H, 12'($urandom_range(240, 1080)));
        end else begin
            write_setting(CFG_FRAME_W, 12'($urandom_range(1, 4095)));
            write_setting(CFG_FRAME_H, 12'($urandom_range(1, 4095)));
        end
        write_setting(CFG_HOME_PAN, 12'($urandom_range(0, 1023)));
        write_setting(CFG_HOME_TILT, 12'($urandom_range(0, 1023)));
        for (k = 0; k < ItemsPerPhase; k++) begin
            if (pause_midway && k == ItemsPerPhase / 2) begin
                wait_drain();
            end
            send_random_command();
        end
    endtask

    always @(posedge i_clk) begin : check_serial
        t_serial_beat want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_serial_q.size() == 0) begin
                $error("unexpected beat: tdata %h tlast %b", o_m_axis_tdata, o_m_axis_tlast);
                errors++;
            end else begin
                want = expected_serial_q.pop_front();
                if (o_m_axis_tdata[7:0] !== want.ch) begin
                    $error("serial_byte: expected %h, actual %h", want.ch, o_m_axis_tdata[7:0]);
                    errors++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last_byte: expected %b, actual %b", want.last, o_m_axis_tlast);
                    errors++;
                end
                if (o_m_axis_tdata[17:8] !== want.pan) begin
                    $error("pan_now: expected %0d, actual %0d", want.pan, o_m_axis_tdata[17:8]);
                    errors++;
                end
                if (o_m_axis_tdata[27:18] !== want.tilt) begin
                    $error("tilt_now: expected %0d, actual %0d", want.tilt,
                           o_m_axis_tdata[27:18]);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_positions();
        test_each_command();
        test_dead_bands();
        test_saturation();
        test_frame_extremes();
        test_random_traffic(0, 0, 1'b0);
        test_random_traffic(78, 0, 1'b0);
        test_random_traffic(0, 78, 1'b1);
        test_random_traffic(16, 16, 1'b0);
        wait_drain();
        repeat (12) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS pan_tilt_deadband_stepper_top");
        end else begin
            $display("FAIL pan_tilt_deadband_stepper_top");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/pts_pkg.sv
rtl/core/pts_step.sv
rtl/core/pts_ser.sv
rtl/core/pan_tilt_deadband_stepper_top.sv
tb/sv/tb_pan_tilt_deadband_stepper_top.sv
